// ===== design/tms_pkg.sv =====
// Shared types, codes and constants for the transform matrix stack.
// No dependencies; imported by every design and checker file.
package tms_pkg;

    localparam int NUM_STACKS            = 3;
    localparam int MAT_WORDS             = 16;
    localparam int DEF_STACK_LEVELS      = 32;
    localparam int DEF_FRACTION_BITS     = 16;

    localparam logic [2:0] OP_SELECT     = 3'd0;
    localparam logic [2:0] OP_IDENTITY   = 3'd1;
    localparam logic [2:0] OP_LOAD_ELEM  = 3'd2;
    localparam logic [2:0] OP_MULT_ELEM  = 3'd3;
    localparam logic [2:0] OP_PUSH       = 3'd4;
    localparam logic [2:0] OP_POP        = 3'd5;
    localparam logic [2:0] OP_READ_TOP   = 3'd6;

    localparam logic [1:0] STAT_DONE     = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_EMPTY    = 2'd2;

    localparam logic [1:0] SEL_KEEP      = 2'd3;

    localparam logic [3:0] LAST_WORD     = 4'd15;

    typedef logic signed [31:0] t_word;

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic acc_clr;
    } t_mac_ctl;

    function automatic logic [31:0] ident_word(logic [3:0] w, int fb);
        logic diag;
        diag = (w == 4'd0) || (w == 4'd5) || (w == 4'd10) || (w == 4'd15);
        return diag ? (32'd1 << fb) : 32'd0;
    endfunction

endpackage

// ===== design/transform_matrix_stack.sv =====
// Top level: three 4x4 matrix stacks held in one synchronous word memory,
// sequencer for select, identity, load, multiply, push, pop and read. Uses tms_pkg, tms_mac.
//
// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+------------------------------------
// in       | into      | i_in_valid / o_in_stall | operation, stack_select, element_*
// out      | out of    | o_out_valid / i_out_stall| result_value/index, last, status
//
// One item at a time. Identity and load commit write one memory word per step.
// Push reads then writes each word, each write trailing its read by one word.
// Read top reads each word, then outputs it. Multiply commit is bounded by the
// single shared multiplier (per row 4 word reads, then 4 dot products).
// Output stalls hold the sequencer.
// Reset is synchronous; no clearing pass, level zero reads as identity until
// written.
module transform_matrix_stack #(
    parameter int STACK_LEVELS  = tms_pkg::DEF_STACK_LEVELS,
    parameter int FRACTION_BITS = tms_pkg::DEF_FRACTION_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [2:0]           i_operation,
    input  logic [1:0]           i_stack_select,
    input  logic [3:0]           i_element_index,
    input  tms_pkg::t_word       i_element_value,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output tms_pkg::t_word       o_result_value,
    output logic [3:0]           o_result_index,
    output logic                 o_last,
    output logic [1:0]           o_status
);
    import tms_pkg::*;

    localparam int LVL_W = (STACK_LEVELS > 1) ? $clog2(STACK_LEVELS) : 1;
    localparam int ROWS  = NUM_STACKS * STACK_LEVELS;
    localparam int RW    = $clog2(ROWS);
    localparam int AW    = RW + 4;
    localparam int DEPTH = ROWS * MAT_WORDS;
    localparam int VW    = NUM_STACKS * MAT_WORDS;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DONE = 4'd1;
    localparam logic [3:0] S_FILL = 4'd2;
    localparam logic [3:0] S_PUSH = 4'd3;
    localparam logic [3:0] S_RDI  = 4'd4;
    localparam logic [3:0] S_RDW  = 4'd5;
    localparam logic [3:0] S_MRI  = 4'd6;
    localparam logic [3:0] S_MRC  = 4'd7;
    localparam logic [3:0] S_MUL  = 4'd8;
    localparam logic [3:0] S_ACC  = 4'd9;
    localparam logic [3:0] S_WB   = 4'd10;

    logic [3:0]       r_state, n_state;
    logic [2:0]       r_op;
    logic [1:0]       r_status, n_status;
    logic [4:0]       r_w, n_w;
    logic [1:0]       r_k, n_k, r_row, n_row, r_col, n_col;
    logic [1:0]       r_cur, n_cur;
    logic [LVL_W-1:0] r_lvl [NUM_STACKS];
    logic             lvl_inc, lvl_dec;
    logic             r_wpend, n_wpend;
    logic [3:0]       r_wword, n_wword;

    t_word            r_staged [MAT_WORDS];
    t_word            r_rowbuf [4];

    logic [31:0]      r_mem [DEPTH];
    logic [31:0]      r_rd_data;
    logic             r_rd_inv;
    logic [3:0]       r_rd_word;
    logic [VW-1:0]    r_vld;

    logic             accept, out_free, out_load;
    logic [LVL_W-1:0] top_lvl, wr_lvl;
    logic             rd_en, wr_en, wr_up;
    logic [3:0]       rd_word, wr_word;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic [31:0]      wr_data, rd_value;
    logic [RW-1:0]    rd_row, wr_row;

    t_word            n_out_value;
    logic [3:0]       n_out_index;
    logic             n_out_last;
    logic [1:0]       n_out_status;
    logic             r_out_valid;
    t_word            r_out_value;
    logic [3:0]       r_out_index;
    logic             r_out_last;
    logic [1:0]       r_out_status;

    t_mac_ctl         mac_ctl;
    t_word            mac_res;

    tms_mac #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_ctl   (mac_ctl),
        .i_a     (r_rowbuf[r_k]),
        .i_b     (r_staged[{r_col, r_k}]),
        .o_result(mac_res)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign top_lvl    = r_lvl[r_cur];
    assign wr_lvl     = wr_up ? top_lvl + LVL_W'(1) : top_lvl;
    assign rd_row     = RW'(RW'(r_cur) * RW'(STACK_LEVELS) + RW'(top_lvl));
    assign wr_row     = RW'(RW'(r_cur) * RW'(STACK_LEVELS) + RW'(wr_lvl));
    assign rd_addr    = {rd_row, rd_word};
    assign wr_addr    = {wr_row, wr_word};
    assign rd_value   = r_rd_inv ? ident_word(r_rd_word, FRACTION_BITS) : r_rd_data;

    always_comb begin
        n_state      = r_state;
        n_status     = r_status;
        n_w          = r_w;
        n_k          = r_k;
        n_row        = r_row;
        n_col        = r_col;
        n_cur        = r_cur;
        n_wpend      = r_wpend;
        n_wword      = r_wword;
        lvl_inc      = 1'b0;
        lvl_dec      = 1'b0;
        rd_en        = 1'b0;
        rd_word      = r_w[3:0];
        wr_en        = 1'b0;
        wr_up        = 1'b0;
        wr_word      = r_w[3:0];
        wr_data      = r_staged[r_w[3:0]];
        mac_ctl      = '0;
        out_load     = 1'b0;
        n_out_value  = '0;
        n_out_index  = '0;
        n_out_last   = 1'b1;
        n_out_status = r_status;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = STAT_DONE;
                    n_w      = '0;
                    n_state  = S_DONE;
                    case (i_operation)
                        OP_SELECT: begin
                            if (i_stack_select != SEL_KEEP) begin
                                n_cur = i_stack_select;
                            end
                        end
                        OP_IDENTITY: n_state = S_FILL;
                        OP_LOAD_ELEM: begin
                            if (i_element_index == LAST_WORD) begin
                                n_state = S_FILL;
                            end
                        end
                        OP_MULT_ELEM: begin
                            if (i_element_index == LAST_WORD) begin
                                n_k     = '0;
                                n_row   = '0;
                                n_state = S_MRI;
                            end
                        end
                        OP_PUSH: begin
                            if (top_lvl == LVL_W'(STACK_LEVELS - 1)) begin
                                n_status = STAT_FULL;
                            end else begin
                                n_wpend = 1'b0;
                                n_state = S_PUSH;
                            end
                        end
                        OP_POP: begin
                            if (top_lvl == '0) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                lvl_dec = 1'b1;
                            end
                        end
                        OP_READ_TOP: n_state = S_RDI;
                        default: ;
                    endcase
                end
            end
            S_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_FILL: begin
                wr_en = 1'b1;
                if (r_op == OP_IDENTITY) begin
                    wr_data = ident_word(r_w[3:0], FRACTION_BITS);
                end
                n_w = r_w + 5'd1;
                if (r_w[3:0] == LAST_WORD) begin
                    n_state = S_DONE;
                end
            end
            S_PUSH: begin
                wr_en   = r_wpend;
                wr_up   = 1'b1;
                wr_word = r_wword;
                wr_data = rd_value;
                if (r_w[4]) begin
                    lvl_inc = 1'b1;
                    n_state = S_DONE;
                end else begin
                    rd_en   = 1'b1;
                    n_wpend = 1'b1;
                    n_wword = r_w[3:0];
                    n_w     = r_w + 5'd1;
                end
            end
            S_RDI: begin
                rd_en   = 1'b1;
                n_state = S_RDW;
            end
            S_RDW: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    n_out_value  = rd_value;
                    n_out_index  = r_w[3:0];
                    n_out_last   = (r_w[3:0] == LAST_WORD);
                    n_out_status = STAT_DONE;
                    n_w          = r_w + 5'd1;
                    n_state      = (r_w[3:0] == LAST_WORD) ? S_IDLE : S_RDI;
                end
            end
            S_MRI: begin
                rd_en   = 1'b1;
                rd_word = {r_k, r_row};
                n_state = S_MRC;
            end
            S_MRC: begin
                n_k = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    n_col           = '0;
                    mac_ctl.acc_clr = 1'b1;
                    n_state         = S_MUL;
                end else begin
                    n_state = S_MRI;
                end
            end
            S_MUL: begin
                mac_ctl.mul_en = 1'b1;
                n_state        = S_ACC;
            end
            S_ACC: begin
                mac_ctl.acc_en = 1'b1;
                n_k            = r_k + 2'd1;
                n_state        = (r_k == 2'd3) ? S_WB : S_MUL;
            end
            S_WB: begin
                wr_en           = 1'b1;
                wr_word         = {r_col, r_row};
                wr_data         = mac_res;
                mac_ctl.acc_clr = 1'b1;
                n_k             = '0;
                n_col           = r_col + 2'd1;
                if (r_col != 2'd3) begin
                    n_state = S_MUL;
                end else if (r_row == 2'd3) begin
                    n_state = S_DONE;
                end else begin
                    n_row   = r_row + 2'd1;
                    n_state = S_MRI;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur       <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
            for (int s = 0; s < NUM_STACKS; s++) begin
                r_lvl[s] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_out_valid <= out_load || (r_out_valid && i_out_stall);
            if (lvl_inc) begin
                r_lvl[r_cur] <= top_lvl + LVL_W'(1);
            end else if (lvl_dec) begin
                r_lvl[r_cur] <= top_lvl - LVL_W'(1);
            end
            if (wr_en && (wr_lvl == '0)) begin
                r_vld[{r_cur, wr_word}] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_w      <= n_w;
        r_k      <= n_k;
        r_row    <= n_row;
        r_col    <= n_col;
        r_wpend  <= n_wpend;
        r_wword  <= n_wword;
        if (accept) begin
            r_op <= i_operation;
            if ((i_operation == OP_LOAD_ELEM) || (i_operation == OP_MULT_ELEM)) begin
                r_staged[i_element_index] <= i_element_value;
            end
        end
        if (r_state == S_MRC) begin
            r_rowbuf[r_k] <= rd_value;
        end
        if (out_load) begin
            r_out_value  <= n_out_value;
            r_out_index  <= n_out_index;
            r_out_last   <= n_out_last;
            r_out_status <= n_out_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_word <= rd_word;
            r_rd_inv  <= (top_lvl == '0) && !r_vld[{r_cur, rd_word}];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_result_index = r_out_index;
    assign o_last         = r_out_last;
    assign o_status       = r_out_status;

endmodule

// ===== design/tms_mac.sv =====
// Multiply-accumulate unit: one 32x32 product per step, 66-bit sum,
// arithmetic shift by the fraction width and saturation. Uses tms_pkg.
module tms_mac #(
    parameter int FRACTION_BITS = tms_pkg::DEF_FRACTION_BITS
) (
    input  logic              i_clk,
    input  tms_pkg::t_mac_ctl i_ctl,
    input  tms_pkg::t_word    i_a,
    input  tms_pkg::t_word    i_b,
    output tms_pkg::t_word    o_result
);
    import tms_pkg::*;

    logic signed [63:0] r_prod;
    logic signed [65:0] r_acc;
    logic signed [65:0] shifted;
    logic [65:31]       hi;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_a * i_b;
        end
        if (i_ctl.acc_clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc_en) begin
            r_acc <= r_acc + 66'(r_prod);
        end
    end

    always_comb begin
        shifted = r_acc >>> FRACTION_BITS;
        hi      = shifted[65:31];
        if ((&hi) || !(|hi)) begin
            o_result = shifted[31:0];
        end else if (shifted[65]) begin
            o_result = 32'sh8000_0000;
        end else begin
            o_result = 32'sh7fff_ffff;
        end
    end

endmodule

// ===== design/tms_check.sv =====
// Port-level checker for transform_matrix_stack, attached by bind.
// Depends on tms_pkg and the top level's port list.
module tms_check (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic [2:0]           i_operation,
    input logic [1:0]           i_stack_select,
    input logic [3:0]           i_element_index,
    input tms_pkg::t_word       i_element_value,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input tms_pkg::t_word       o_result_value,
    input logic [3:0]           o_result_index,
    input logic                 o_last,
    input logic [1:0]           o_status
);
    import tms_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_value)
            && $stable(o_result_index) && $stable(o_last) && $stable(o_status))
        else $error("stalled output word changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while previous word in work");

    a_mid_read_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> (o_status == STAT_DONE) && (o_result_index != LAST_WORD))
        else $error("bad non-final read word");

    a_error_status_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != STAT_DONE) |-> o_last && (o_result_index == 4'd0)
            && (o_result_value == 32'sd0))
        else $error("status word not a single zero result");

endmodule

bind transform_matrix_stack tms_check u_tms_check (.*);
